>>> rtl/core/nsc_pkg.sv
// Shared constants, types and helper functions for the NMEA sentence checker.
// Used by nmea_sentence_checker_core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

    localparam int unsigned LenW = 10;
    localparam int unsigned CntW = 16;

    localparam logic [LenW-1:0] MaxLenReset = 10'd128;
    localparam logic [LenW-1:0] HeaderLen   = 10'd3;
    localparam logic [LenW-1:0] MinStarLen  = 10'd8;

    localparam logic [23:0] SyncGp = 24'h244750;
    localparam logic [23:0] SyncGn = 24'h24474E;

    localparam logic [7:0] CharLf    = 8'h0a;
    localparam logic [7:0] CharStar  = 8'h2a;
    localparam logic [7:0] CharG     = 8'h47;
    localparam logic [7:0] CharN     = 8'h4E;
    localparam logic [7:0] CharP     = 8'h50;
    localparam logic [7:0] CharNine  = 8'h39;
    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] HexAlphaOffset = 8'h37;

    localparam logic [23:0] IdGga = 24'h474741;
    localparam logic [23:0] IdVtg = 24'h565447;
    localparam logic [23:0] IdRmc = 24'h524D43;

    typedef enum logic [1:0] {
        STATUS_VALID    = 2'd0,
        STATUS_NO_STAR  = 2'd1,
        STATUS_CSUM_ERR = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GGA   = 2'd1,
        KIND_VTG   = 2'd2,
        KIND_RMC   = 2'd3
    } kind_t;

    // Hex digit decode without range checking: anything above '9' is taken
    // as an uppercase letter.
    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        if (c > CharNine)
        begin
            d = c - HexAlphaOffset;
        end
        else
        begin
            d = c - CharZero;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/nmea_sentence_checker_core.sv
// NMEA sentence checker top level: framing, checksum check and result register.
// Depends on nsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per beat and finds sentences that open with "$GP" or
// "$GN" (a new header restarts framing at any time, silently dropping a
// sentence in progress). A sentence ends with one result beat on LF (valid,
// missing star or checksum mismatch) or when its byte count reaches or passes
// max_sentence_length (overflow). Each byte is processed in the cycle it is
// accepted and its result, if any, is held in an output register, so a byte
// can be accepted on every clock while the result register is empty or being
// drained. The error counters wrap at 16 bits.
// max_sentence_length is written through cfg_write_en/cfg_write_data and
// resets to 128.
module nmea_sentence_checker_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write_en,
    input  wire logic [9:0]              cfg_write_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [7:0]              rx_byte,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output nsc_pkg::status_t             status,
    output logic                         talker_gn,
    output nsc_pkg::kind_t               sentence_kind,
    output logic [7:0]                   checksum_received,
    output logic [7:0]                   checksum_computed,
    output logic [nsc_pkg::LenW-1:0]     sentence_length,
    output logic [nsc_pkg::CntW-1:0]     star_error_total,
    output logic [nsc_pkg::CntW-1:0]     checksum_error_total
);
    import nsc_pkg::*;

    // Framing state.
    logic [LenW-1:0]  max_len_reg;
    logic [23:0]      sync_reg,     sync_next;
    logic             in_sent_reg,  in_sent_next;
    logic [LenW-1:0]  count_reg,    count_next;
    logic [7:0]       xor_reg,      xor_next;
    logic [7:0]       tail_reg [4];
    logic [7:0]       tail_next [4];
    logic [7:0]       id_reg [3];
    logic [7:0]       id_next [3];
    logic             talker_reg,   talker_next;
    logic [CntW-1:0]  star_cnt_reg, star_cnt_next;
    logic [CntW-1:0]  crc_cnt_reg,  crc_cnt_next;

    // Result register.
    logic             out_valid_reg;
    status_t          status_reg,   status_next;
    kind_t            kind_reg,     kind_next;
    logic             gn_reg;
    logic [7:0]       rcvd_reg,     rcvd_next;
    logic [7:0]       calc_reg,     calc_next;
    logic [LenW-1:0]  len_reg;
    logic             emit;

    logic             accept;
    logic [LenW-1:0]  pos_plus;
    logic [23:0]      id_word;
    logic [7:0]       hex_hi;
    logic [7:0]       hex_lo;
    logic [7:0]       rcvd_raw;
    logic [7:0]       calc_raw;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign pos_plus = count_reg + 10'd1;
    // A checksum can only pass at a count of eight or more, by which time the
    // three identifier bytes are already held.
    assign id_word  = {id_reg[0], id_reg[1], id_reg[2]};
    assign hex_hi   = hex_digit(tail_reg[2]);
    assign hex_lo   = hex_digit(tail_reg[1]);
    assign rcvd_raw = {hex_hi[3:0], 4'h0} | hex_lo;
    // The running XOR already holds the star, the hex pair and CR; XOR them out.
    assign calc_raw = xor_reg ^ tail_reg[0] ^ tail_reg[1] ^ tail_reg[2] ^ tail_reg[3];

    always_comb
    begin
        sync_next     = {sync_reg[15:0], rx_byte};
        in_sent_next  = in_sent_reg;
        count_next    = count_reg;
        xor_next      = xor_reg;
        tail_next     = tail_reg;
        id_next       = id_reg;
        talker_next   = talker_reg;
        star_cnt_next = star_cnt_reg;
        crc_cnt_next  = crc_cnt_reg;
        emit          = 1'b0;
        status_next   = STATUS_VALID;
        kind_next     = KIND_OTHER;
        rcvd_next     = 8'h00;
        calc_next     = 8'h00;

        if (sync_next == SyncGp || sync_next == SyncGn)
        begin
            in_sent_next = 1'b1;
            talker_next  = (sync_next == SyncGn);
            count_next   = HeaderLen;
            xor_next     = CharG ^ ((sync_next == SyncGn) ? CharN : CharP);
            for (int i = 0; i < 4; i++)
            begin
                tail_next[i] = 8'h00;
            end
            for (int i = 0; i < 3; i++)
            begin
                id_next[i] = 8'h00;
            end
        end
        else if (in_sent_reg)
        begin
            if (count_reg == 10'd3)
            begin
                id_next[0] = rx_byte;
            end
            if (count_reg == 10'd4)
            begin
                id_next[1] = rx_byte;
            end
            if (count_reg == 10'd5)
            begin
                id_next[2] = rx_byte;
            end
            count_next = pos_plus;

            if (pos_plus >= max_len_reg)
            begin
                in_sent_next = 1'b0;
                emit         = 1'b1;
                status_next  = STATUS_OVERFLOW;
            end
            else if (rx_byte == CharLf)
            begin
                in_sent_next = 1'b0;
                emit         = 1'b1;
                if (pos_plus < MinStarLen || tail_reg[3] != CharStar)
                begin
                    star_cnt_next = star_cnt_reg + 16'd1;
                    status_next   = STATUS_NO_STAR;
                end
                else
                begin
                    rcvd_next = rcvd_raw;
                    calc_next = calc_raw;
                    if (rcvd_raw == calc_raw)
                    begin
                        status_next = STATUS_VALID;
                        if (id_word == IdGga)
                        begin
                            kind_next = KIND_GGA;
                        end
                        else if (id_word == IdVtg)
                        begin
                            kind_next = KIND_VTG;
                        end
                        else if (id_word == IdRmc)
                        begin
                            kind_next = KIND_RMC;
                        end
                    end
                    else
                    begin
                        crc_cnt_next = crc_cnt_reg + 16'd1;
                        status_next  = STATUS_CSUM_ERR;
                    end
                end
            end
            else
            begin
                xor_next     = xor_reg ^ rx_byte;
                tail_next[3] = tail_reg[2];
                tail_next[2] = tail_reg[1];
                tail_next[1] = tail_reg[0];
                tail_next[0] = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MaxLenReset;
            sync_reg      <= '0;
            in_sent_reg   <= 1'b0;
            count_reg     <= '0;
            xor_reg       <= '0;
            talker_reg    <= 1'b0;
            star_cnt_reg  <= '0;
            crc_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                tail_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                id_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_len_reg <= cfg_write_data;
            end
            if (accept)
            begin
                sync_reg     <= sync_next;
                in_sent_reg  <= in_sent_next;
                count_reg    <= count_next;
                xor_reg      <= xor_next;
                tail_reg     <= tail_next;
                id_reg       <= id_next;
                talker_reg   <= talker_next;
                star_cnt_reg <= star_cnt_next;
                crc_cnt_reg  <= crc_cnt_next;
            end
            if (accept)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload carries no reset; it is loaded only with a result beat.
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            status_reg <= status_next;
            kind_reg   <= kind_next;
            gn_reg     <= talker_reg;
            rcvd_reg   <= rcvd_next;
            calc_reg   <= calc_next;
            len_reg    <= count_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign status               = status_reg;
    assign talker_gn            = gn_reg;
    assign sentence_kind        = kind_reg;
    assign checksum_received    = rcvd_reg;
    assign checksum_computed    = calc_reg;
    assign sentence_length      = len_reg;
    assign star_error_total     = star_cnt_reg;
    assign checksum_error_total = crc_cnt_reg;

endmodule

`default_nettype wire

>>> tb/nsc_sentence_monitor.sv
// Watches both channels of nmea_sentence_checker_core, predicts the sentence reports
// from the accepted bytes and compares every result beat with the oldest expectation.
// Depends on nsc_pkg for the status and kind types and the framing constants.
`timescale 1ns / 1ps

module nsc_sentence_monitor (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic [9:0]        cfg_write_data,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  nsc_pkg::status_t       status,
    input  wire logic              talker_gn,
    input  nsc_pkg::kind_t         sentence_kind,
    input  wire logic [7:0]        checksum_received,
    input  wire logic [7:0]        checksum_computed,
    input  wire logic [9:0]        sentence_length,
    input  wire logic [15:0]       star_error_total,
    input  wire logic [15:0]       checksum_error_total,
    output int                     mismatch_count,
    output int                     reports_due
);
    import nsc_pkg::*;

    typedef struct packed {
        status_t     status;
        logic        talker_gn;
        kind_t       kind;
        logic [7:0]  sum_rx;
        logic [7:0]  sum_calc;
        logic [9:0]  length;
        logic [15:0] star_total;
        logic [15:0] sum_total;
    } sentence_report_t;

    sentence_report_t sentence_reports[$];

    logic [9:0]  length_limit;
    logic [23:0] hunt_window;
    logic        framing;
    logic [9:0]  frame_count;
    logic [7:0]  xor_acc;
    logic [7:0]  last_bytes[4];
    logic [7:0]  msg_id[3];
    logic        talker_n;
    logic [15:0] star_faults;
    logic [15:0] sum_faults;
    int          faults;

    function automatic string describe(input sentence_report_t r);
        return $sformatf("status=%0d gn=%0d kind=%0d rx=%02h calc=%02h len=%0d star=%0d sum=%0d",
                         r.status, r.talker_gn, r.kind, r.sum_rx, r.sum_calc, r.length,
                         r.star_total, r.sum_total);
    endfunction

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        return (c > 8'h39) ? c - 8'h37 : c - 8'h30;
    endfunction

    // Advances the framing state by one byte and queues the report it closes, if any.
    task automatic frame_rx_byte(input logic [7:0] b);
        sentence_report_t rep;
        logic [9:0]       pos;
        logic [7:0]       hi;
        logic [7:0]       lo;
        logic             closes;
        closes = 1'b0;
        rep = '0;
        hunt_window = {hunt_window[15:0], b};
        if (hunt_window == SyncGp || hunt_window == SyncGn)
        begin
            framing = 1'b1;
            talker_n = (hunt_window == SyncGn);
            frame_count = HeaderLen;
            xor_acc = CharG ^ (talker_n ? CharN : CharP);
            for (int i = 0; i < 4; i++)
            begin
                last_bytes[i] = 8'h00;
            end
            for (int i = 0; i < 3; i++)
            begin
                msg_id[i] = 8'h00;
            end
        end
        else if (framing)
        begin
            pos = frame_count;
            if (pos >= 10'd3 && pos <= 10'd5)
            begin
                msg_id[pos - 10'd3] = b;
            end
            frame_count = pos + 10'd1;
            rep.talker_gn = talker_n;
            rep.length = frame_count;
            rep.status = STATUS_VALID;
            rep.kind = KIND_OTHER;
            // The length limit wins over LF, so an LF landing on the limit is an overflow.
            if (frame_count >= length_limit)
            begin
                framing = 1'b0;
                closes = 1'b1;
                rep.status = STATUS_OVERFLOW;
            end
            else if (b == CharLf)
            begin
                framing = 1'b0;
                closes = 1'b1;
                if (frame_count < MinStarLen || last_bytes[3] != CharStar)
                begin
                    star_faults = star_faults + 16'd1;
                    rep.status = STATUS_NO_STAR;
                end
                else
                begin
                    hi = hex_value(last_bytes[2]);
                    lo = hex_value(last_bytes[1]);
                    rep.sum_rx = {hi[3:0], 4'h0} | lo;
                    // The running XOR also took in the star, the digits and CR; undo them.
                    rep.sum_calc = xor_acc ^ last_bytes[0] ^ last_bytes[1]
                                   ^ last_bytes[2] ^ last_bytes[3];
                    if (rep.sum_rx == rep.sum_calc)
                    begin
                        if ({msg_id[0], msg_id[1], msg_id[2]} == IdGga)
                        begin
                            rep.kind = KIND_GGA;
                        end
                        else if ({msg_id[0], msg_id[1], msg_id[2]} == IdVtg)
                        begin
                            rep.kind = KIND_VTG;
                        end
                        else if ({msg_id[0], msg_id[1], msg_id[2]} == IdRmc)
                        begin
                            rep.kind = KIND_RMC;
                        end
                    end
                    else
                    begin
                        sum_faults = sum_faults + 16'd1;
                        rep.status = STATUS_CSUM_ERR;
                    end
                end
            end
            else
            begin
                xor_acc = xor_acc ^ b;
                last_bytes[3] = last_bytes[2];
                last_bytes[2] = last_bytes[1];
                last_bytes[1] = last_bytes[0];
                last_bytes[0] = b;
            end
            rep.star_total = star_faults;
            rep.sum_total = sum_faults;
            if (closes)
            begin
                sentence_reports.push_back(rep);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sentence_report_t seen;
        sentence_report_t want;
        if (!rst_n)
        begin
            length_limit = MaxLenReset;
            hunt_window = 24'h0;
            framing = 1'b0;
            frame_count = 10'd0;
            xor_acc = 8'h00;
            for (int i = 0; i < 4; i++)
            begin
                last_bytes[i] = 8'h00;
            end
            for (int i = 0; i < 3; i++)
            begin
                msg_id[i] = 8'h00;
            end
            talker_n = 1'b0;
            star_faults = 16'd0;
            sum_faults = 16'd0;
            sentence_reports.delete();
            faults = 0;
            mismatch_count <= 0;
            reports_due <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                length_limit = cfg_write_data;
            end
            if (in_valid && in_ready)
            begin
                frame_rx_byte(rx_byte);
            end
            if (out_valid && out_ready)
            begin
                seen = '{status, talker_gn, sentence_kind, checksum_received,
                         checksum_computed, sentence_length, star_error_total,
                         checksum_error_total};
                if (sentence_reports.size() == 0)
                begin
                    if (faults < 10)
                    begin
                        $display("%0t: result beat with nothing expected: %s",
                                 $realtime, describe(seen));
                    end
                    faults++;
                end
                else
                begin
                    want = sentence_reports.pop_front();
                    if (seen !== want)
                    begin
                        if (faults < 10)
                        begin
                            $display("%0t: mismatch, expected %s", $realtime, describe(want));
                            $display("%0t:           actual   %s", $realtime, describe(seen));
                        end
                        faults++;
                    end
                end
            end
            mismatch_count <= faults;
            reports_due <= sentence_reports.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Top of the NMEA sentence checker testbench: clock, reset, byte stimulus and verdict.
// Depends on nsc_pkg, nmea_sentence_checker_core and nsc_sentence_monitor.
`timescale 1ns / 1ps

module tb_top;
    import nsc_pkg::*;

    typedef enum int unsigned {
        FORM_VALID,
        FORM_BAD_SUM,
        FORM_LOWER_HEX,
        FORM_NO_STAR,
        FORM_SHORT,
        FORM_CUT,
        FORM_NOISE,
        FORM_LONG
    } form_t;

    localparam logic [7:0] ChDollar = 8'h24;
    localparam logic [7:0] ChComma  = 8'h2c;
    localparam logic [7:0] ChCr     = 8'h0d;
    localparam int         PhaseBytes = 76;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [9:0]  cfg_write_data = 10'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    status_t     status;
    logic        talker_gn;
    kind_t       sentence_kind;
    logic [7:0]  checksum_received;
    logic [7:0]  checksum_computed;
    logic [9:0]  sentence_length;
    logic [15:0] star_error_total;
    logic [15:0] checksum_error_total;
    int          mismatch_count;
    int          reports_due;

    logic        calm = 1'b0;
    logic [9:0]  limit_now = MaxLenReset;
    logic [7:0]  tx_bytes[$];
    int          phase_bytes;

    nmea_sentence_checker_core u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write_en         (cfg_write_en),
        .cfg_write_data       (cfg_write_data),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .rx_byte              (rx_byte),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .status               (status),
        .talker_gn            (talker_gn),
        .sentence_kind        (sentence_kind),
        .checksum_received    (checksum_received),
        .checksum_computed    (checksum_computed),
        .sentence_length      (sentence_length),
        .star_error_total     (star_error_total),
        .checksum_error_total (checksum_error_total)
    );

    nsc_sentence_monitor u_monitor (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write_en         (cfg_write_en),
        .cfg_write_data       (cfg_write_data),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .rx_byte              (rx_byte),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .status               (status),
        .talker_gn            (talker_gn),
        .sentence_kind        (sentence_kind),
        .checksum_received    (checksum_received),
        .checksum_computed    (checksum_computed),
        .sentence_length      (sentence_length),
        .star_error_total     (star_error_total),
        .checksum_error_total (checksum_error_total),
        .mismatch_count       (mismatch_count),
        .reports_due          (reports_due)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // The result side stalls at random except during the calm phase.
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 17);
    end

    initial
    begin
        #2_400_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] pick_text_byte();
        logic [7:0] c;
        if ($urandom_range(99) < 80)
        begin
            c = 8'($urandom_range(8'h20, 8'h7e));
        end
        else
        begin
            c = 8'($urandom_range(0, 255));
        end
        // Keep header, star and LF characters out of the body of a well-formed sentence.
        if (c == ChDollar || c == CharStar || c == CharLf)
        begin
            c = ChComma;
        end
        return c;
    endfunction

    function automatic logic [23:0] pick_ident();
        logic [23:0] id;
        case ($urandom_range(0, 2))
            0: id = IdGga;
            1: id = IdVtg;
            default: id = IdRmc;
        endcase
        case ($urandom_range(0, 4))
            0, 1, 2: ;
            3: id = id ^ (24'h1 << (8 * $urandom_range(0, 2)));
            default: id = {8'($urandom_range(8'h41, 8'h5a)), 8'($urandom_range(8'h41, 8'h5a)),
                           8'($urandom_range(8'h41, 8'h5a))};
        endcase
        return id;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return (lower ? 8'h57 : 8'h37) + 8'(n);
    endfunction

    // For short sentences and noise, body_len is the number of filler bytes.
    task automatic queue_sentence(input form_t form, input int body_len, input logic gn,
                                  input logic [23:0] id);
        logic [7:0] sum;
        logic [7:0] c;
        logic       lower;
        if (form == FORM_NOISE)
        begin
            repeat (body_len) tx_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            tx_bytes.push_back(ChDollar);
            tx_bytes.push_back(CharG);
            tx_bytes.push_back(gn ? CharN : CharP);
            sum = CharG ^ (gn ? CharN : CharP);
            if (form == FORM_SHORT)
            begin
                repeat (body_len) tx_bytes.push_back(pick_text_byte());
                tx_bytes.push_back(CharLf);
            end
            else
            begin
                for (int i = 0; i < body_len; i++)
                begin
                    c = (i < 3) ? id[23 - 8 * i -: 8] : pick_text_byte();
                    tx_bytes.push_back(c);
                    sum = sum ^ c;
                end
                if (form == FORM_BAD_SUM)
                begin
                    sum = sum ^ 8'($urandom_range(1, 255));
                end
                lower = (form == FORM_LOWER_HEX);
                tx_bytes.push_back(form == FORM_NO_STAR ? pick_text_byte() : CharStar);
                tx_bytes.push_back(hex_char(sum[7:4], lower));
                tx_bytes.push_back(hex_char(sum[3:0], lower));
                tx_bytes.push_back(ChCr);
                tx_bytes.push_back(CharLf);
                // A cut sentence loses its end and is dropped when the next header arrives.
                if (form == FORM_CUT)
                begin
                    repeat ($urandom_range(1, body_len + 5)) void'(tx_bytes.pop_back());
                end
            end
        end
    endtask

    task automatic send_bytes();
        while (tx_bytes.size() > 0)
        begin
            if (!calm && $urandom_range(99) < 13)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 2)) @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte <= tx_bytes.pop_front();
            @(posedge clk);
            while (!in_ready)
            begin
                @(posedge clk);
            end
            phase_bytes++;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [9:0] value);
        drain();
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        limit_now = value;
    endtask

    initial
    begin
        logic [9:0] limits[6];
        form_t      form;
        int         pick;
        int         body_len;
        limits = '{10'd1023, 10'd8, 10'd0, 10'd3, 10'd57, 10'd128};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: minimal GGA, an LF landing exactly on the shortest legal count,
        // a header followed straight by LF, and two extreme noise bytes.
        queue_sentence(FORM_VALID, 3, 1'b0, IdGga);
        queue_sentence(FORM_VALID, 0, 1'b1, IdRmc);
        queue_sentence(FORM_SHORT, 0, 1'b0, IdVtg);
        tx_bytes.push_back(8'hff);
        tx_bytes.push_back(8'h00);
        send_bytes();

        for (int p = 0; p <= 6; p++)
        begin
            if (p > 0)
            begin
                write_limit(limits[p - 1]);
            end
            calm <= (p == 5);
            phase_bytes = 0;
            if (limit_now == 10'd1023)
            begin
                // LF falls exactly on the largest limit.
                queue_sentence(FORM_VALID, 1015, 1'($urandom_range(0, 1)), pick_ident());
                send_bytes();
            end
            while (phase_bytes < PhaseBytes)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                begin
                    form = FORM_VALID;
                end
                else if (pick < 60)
                begin
                    form = FORM_BAD_SUM;
                end
                else if (pick < 65)
                begin
                    form = FORM_LOWER_HEX;
                end
                else if (pick < 73)
                begin
                    form = FORM_NO_STAR;
                end
                else if (pick < 80)
                begin
                    form = FORM_SHORT;
                end
                else if (pick < 87)
                begin
                    form = FORM_CUT;
                end
                else if (pick < 93)
                begin
                    form = FORM_NOISE;
                end
                else
                begin
                    form = FORM_LONG;
                end
                if (form == FORM_SHORT)
                begin
                    body_len = $urandom_range(0, 4);
                end
                else if (form == FORM_NOISE)
                begin
                    body_len = $urandom_range(1, 6);
                end
                else if (form == FORM_LONG && limit_now >= 10'd12 && limit_now <= 10'd200)
                begin
                    // Straddle the limit: one byte short, exactly on it, or past it.
                    body_len = int'(limit_now) - 9 + $urandom_range(0, 2);
                end
                else if ($urandom_range(99) < 90)
                begin
                    body_len = $urandom_range(0, 20);
                end
                else
                begin
                    body_len = $urandom_range(21, 70);
                end
                queue_sentence(form, body_len, 1'($urandom_range(0, 1)), pick_ident());
                send_bytes();
            end
        end

        drain();
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
